>>> rtl/tth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn-to-heading controller package
// Shared constants, register indexes and the configuration bundle type.
// ----------------------------------------------------------------------------
package tth_pkg;

   // Field widths.
   localparam int HeadingWidth  = 15;
   localparam int DriveWidth    = 16;
   localparam int AngleWidth    = 16;
   localparam int SpeedWidth    = 15;
   localparam int GainWidth     = 16;
   localparam int TolWidth      = 13;
   localparam int CsrDataWidth  = 16;
   localparam int CsrIndexWidth = 3;

   // Running average: 15 integer bits and 9 fraction bits.
   localparam int FracBits = 9;
   localparam int AvgWidth = HeadingWidth + FracBits;

   // Default divisor of the running average.
   localparam int AverageDivisorDefault = 8;

   // Angle constants in 1/64 degree.
   localparam int Deg180   = 11520;
   localparam int Deg359   = 22976;
   localparam int Deg360   = 23040;
   localparam int Deg10    = 640;
   localparam int HalfDeg  = 32;
   localparam int DriveMax = 32767;

   // Configuration register indexes.
   typedef enum logic [CsrIndexWidth-1:0] {
      REG_TARGET_ANGLE      = 3'd0,
      REG_AZIMUTH_MODE      = 3'd1,
      REG_BASE_SPEED        = 3'd2,
      REG_ADJUST_GAIN       = 3'd3,
      REG_ACTUAL_TOLERANCE  = 3'd4,
      REG_AVERAGE_TOLERANCE = 3'd5
   } csr_index_type;

   // Configuration bundle handed from the register file to the datapath.
   typedef struct packed {
      logic signed [AngleWidth-1:0] target_angle;
      logic                         azimuth_mode;
      logic        [SpeedWidth-1:0] base_speed;
      logic        [GainWidth-1:0]  adjust_gain;
      logic        [TolWidth-1:0]   actual_tolerance;
      logic        [TolWidth-1:0]   average_tolerance;
   } cfg_type;

endpackage

>>> rtl/tth_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn-to-heading controller channels
// Valid/ready channels for heading samples and drive results.
// ----------------------------------------------------------------------------

// Heading sample channel.
interface tth_req_if;
   logic                             valid;
   logic                             ready;
   logic [tth_pkg::HeadingWidth-1:0] heading_change;

   modport source (output valid, output heading_change, input ready);
   modport sink   (input valid, input heading_change, output ready);
endinterface

// Drive result channel.
interface tth_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [tth_pkg::DriveWidth-1:0] drive;
   logic                                  finished;
   logic [tth_pkg::HeadingWidth-1:0]      average_angle;

   modport source (output valid, output drive, output finished, output average_angle,
                   input ready);
   modport sink   (input valid, input drive, input finished, input average_angle,
                   output ready);
endinterface

>>> rtl/tth_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn-to-heading controller register file
// Holds the six configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module tth_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [tth_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [tth_pkg::CsrDataWidth-1:0]     csr_wdata,
   output tth_pkg::cfg_type                     cfg
);

   tth_pkg::cfg_type cfg_ff;
   tth_pkg::cfg_type cfg_in;

   // Decode the write; an index beyond the list changes nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (tth_pkg::csr_index_type'(csr_index))
            tth_pkg::REG_TARGET_ANGLE: begin
               cfg_in.target_angle = $signed(csr_wdata[tth_pkg::AngleWidth-1:0]);
            end
            tth_pkg::REG_AZIMUTH_MODE: begin
               cfg_in.azimuth_mode = csr_wdata[0];
            end
            tth_pkg::REG_BASE_SPEED: begin
               cfg_in.base_speed = csr_wdata[tth_pkg::SpeedWidth-1:0];
            end
            tth_pkg::REG_ADJUST_GAIN: begin
               cfg_in.adjust_gain = csr_wdata[tth_pkg::GainWidth-1:0];
            end
            tth_pkg::REG_ACTUAL_TOLERANCE: begin
               cfg_in.actual_tolerance = csr_wdata[tth_pkg::TolWidth-1:0];
            end
            tth_pkg::REG_AVERAGE_TOLERANCE: begin
               cfg_in.average_tolerance = csr_wdata[tth_pkg::TolWidth-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // All registers reset to zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/tth_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn-to-heading controller datapath
// Input register, single-pass drive and average logic, and result register.
// ----------------------------------------------------------------------------
module tth_core #(
   parameter int AverageDivisor = tth_pkg::AverageDivisorDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tth_pkg::cfg_type                       cfg,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [tth_pkg::HeadingWidth-1:0]       in_heading,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic signed [tth_pkg::DriveWidth-1:0]  out_drive,
   output logic                                   out_finished,
   output logic [tth_pkg::HeadingWidth-1:0]       out_average_angle
);

   localparam int HW = tth_pkg::HeadingWidth;
   localparam int AW = tth_pkg::AvgWidth;
   localparam int FB = tth_pkg::FracBits;

   // Exact division by the divisor: multiply by a rounded-up reciprocal and shift.
   localparam int DivShift = AW + $clog2(AverageDivisor);
   localparam logic [AW:0] DivRecip =
      (AW+1)'(((64'd1 << DivShift) + 64'(AverageDivisor) - 64'd1) / AverageDivisor);

   // Pipeline registers.
   logic                      s1_valid_ff, s1_valid_in;
   logic [HW-1:0]             heading_ff, heading_in;
   logic                      out_valid_ff, out_valid_in;
   logic signed [tth_pkg::DriveWidth-1:0] drive_ff, drive_in;
   logic                      finished_ff, finished_in;
   logic [HW-1:0]             avg_angle_ff, avg_angle_in;
   logic [AW-1:0]             average_ff, average_in;

   logic load_out;

   // Setpoint and direction.
   logic signed [17:0] sp_raw;
   logic signed [17:0] sp;
   logic               cw;

   // Drive magnitude.
   logic signed [18:0] diff;
   logic        [17:0] err;
   logic        [33:0] gain_prod;
   logic        [18:0] mag_sum;
   logic        [14:0] mag;
   logic signed [tth_pkg::DriveWidth-1:0] mag_pos;

   // Band tests.
   logic        [HW-1:0] hc;
   logic signed [19:0]   hc_s;
   logic signed [19:0]   band_lo;
   logic signed [19:0]   band_hi;

   // Running average.
   logic [2*AW:0]      avg_prod;
   logic [2*AW:0]      smp_prod;
   logic [AW-1:0]      avg_quot;
   logic [AW-1:0]      smp_quot;
   logic [AW-1:0]      sample_fx;
   logic signed [26:0] avg_s;
   logic signed [26:0] atol_fx;
   logic signed [26:0] hc_fx;
   logic               avg_ok;
   logic               band_ok;

   // Handshake: the result register loads when empty or drained.
   assign load_out = !out_valid_ff || out_ready;
   assign in_ready = !s1_valid_ff || load_out;

   // Effective setpoint: azimuth wrap, then half-degree nudge toward 180.
   always_comb begin
      sp_raw = 18'(cfg.target_angle);
      if (cfg.azimuth_mode && cfg.target_angle < 0) begin
         sp_raw = sp_raw + 18'(tth_pkg::Deg360);
      end
      cw = sp_raw < 18'(tth_pkg::Deg180);
      sp = sp_raw;
      if (cfg.azimuth_mode) begin
         sp = cw ? sp_raw + 18'(tth_pkg::HalfDeg) : sp_raw - 18'(tth_pkg::HalfDeg);
      end
   end

   // Magnitude: base speed plus gain times absolute error, saturated.
   always_comb begin
      diff      = 19'(sp) - $signed({4'b0, heading_ff});
      err       = diff[18] ? 18'(-diff) : 18'(diff);
      gain_prod = 34'(cfg.adjust_gain) * 34'(err);
      mag_sum   = 19'(cfg.base_speed) + 19'(gain_prod[33:16]);
      mag       = (mag_sum > 19'(tth_pkg::DriveMax)) ? 15'(tth_pkg::DriveMax) : mag_sum[14:0];
      mag_pos   = $signed({1'b0, mag});
   end

   // Sign of the drive from the tolerance band.
   always_comb begin
      hc = heading_ff;
      if (cw && heading_ff > HW'(tth_pkg::Deg359)) begin
         hc = '0;
      end
      hc_s    = $signed({5'b0, hc});
      band_lo = 20'(sp) - $signed({7'b0, cfg.actual_tolerance});
      band_hi = 20'(sp) + $signed({7'b0, cfg.actual_tolerance});
      if (cw) begin
         if (hc_s < band_lo) begin
            drive_in = -mag_pos;
         end else if (hc_s > band_hi) begin
            drive_in = mag_pos;
         end else begin
            drive_in = '0;
         end
      end else begin
         if (hc_s > band_hi || heading_ff < HW'(tth_pkg::Deg10)) begin
            drive_in = mag_pos;
         end else if (hc_s < band_lo) begin
            drive_in = -mag_pos;
         end else begin
            drive_in = '0;
         end
      end
   end

   // Running average update and finish test against the new average.
   always_comb begin
      sample_fx  = {heading_ff, {FB{1'b0}}};
      avg_prod   = (2*AW+1)'(average_ff) * (2*AW+1)'(DivRecip);
      smp_prod   = (2*AW+1)'(sample_fx) * (2*AW+1)'(DivRecip);
      avg_quot   = AW'(avg_prod >> DivShift);
      smp_quot   = AW'(smp_prod >> DivShift);
      average_in = average_ff - avg_quot + smp_quot;

      avg_s   = $signed({3'b0, average_in});
      atol_fx = $signed({5'b0, cfg.average_tolerance, {FB{1'b0}}});
      hc_fx   = $signed({3'b0, hc, {FB{1'b0}}});
      avg_ok  = (avg_s - atol_fx < hc_fx) && (hc_fx < avg_s + atol_fx);
      band_ok = (band_lo < hc_s) && (hc_s < band_hi);

      finished_in  = avg_ok && band_ok;
      avg_angle_in = average_in[AW-1:FB];
   end

   // Next-state of the two pipeline stages.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      heading_in   = heading_ff;
      out_valid_in = out_valid_ff;
      if (in_ready) begin
         s1_valid_in = in_valid;
         if (in_valid) begin
            heading_in = in_heading;
         end
      end
      if (load_out) begin
         out_valid_in = s1_valid_ff;
      end
   end

   // Control state and the running average clear at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         average_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (load_out && s1_valid_ff) begin
            average_ff <= average_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      heading_ff <= heading_in;
      if (load_out && s1_valid_ff) begin
         drive_ff     <= drive_in;
         finished_ff  <= finished_in;
         avg_angle_ff <= avg_angle_in;
      end
   end

   assign out_valid         = out_valid_ff;
   assign out_drive         = drive_ff;
   assign out_finished      = finished_ff;
   assign out_average_angle = avg_angle_ff;

endmodule

>>> rtl/turn_to_heading_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn-to-heading controller
// Turns heading samples into a saturated turn drive and a finished flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one heading sample per transaction; rsp_chan returns one
//   result per sample (drive, finished, average_angle) in the same order.
//   Configuration is written through csr_wr_en / csr_index / csr_wdata while
//   no transaction is in flight; an unknown index is ignored.
// Flow and throughput:
//   An accepted sample passes the input register, then the result register.
//   One sample is accepted every cycle while rsp_chan is not stalled; the
//   rate is set by the running-average update, which feeds back each sample.
// Reset:
//   Synchronous reset clears the configuration registers, the running
//   average and both stages' valid flags; rsp_chan.valid is low after reset.
// Stalls:
//   A stalled result holds in the output register; one more sample waits in
//   the input register, and req_chan.ready drops only when both are full.
// ----------------------------------------------------------------------------
module turn_to_heading_controller_top #(
   parameter int AVERAGE_DIVISOR = tth_pkg::AverageDivisorDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   tth_req_if.sink                           req_chan,
   tth_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [tth_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [tth_pkg::CsrDataWidth-1:0]  csr_wdata
);

   tth_pkg::cfg_type cfg;

   // Configuration registers.
   tth_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Datapath with input and result registers.
   tth_core #(
      .AverageDivisor (AVERAGE_DIVISOR)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .in_valid          (req_chan.valid),
      .in_ready          (req_chan.ready),
      .in_heading        (req_chan.heading_change),
      .out_valid         (rsp_chan.valid),
      .out_ready         (rsp_chan.ready),
      .out_drive         (rsp_chan.drive),
      .out_finished      (rsp_chan.finished),
      .out_average_angle (rsp_chan.average_angle)
   );

endmodule

>>> rtl/tth_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn-to-heading controller checker
// Port-level assertions on reset, latency, stalls and drive range.
// ----------------------------------------------------------------------------
module tth_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [tth_pkg::DriveWidth-1:0] rsp_drive
);

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A fresh result always comes from an earlier accepted transaction.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without matching request");

   // A stalled result stays offered with the same drive.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
      else $error("stalled result changed");

   // The saturated drive never reaches the most negative code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive != -16'sd32768)
      else $error("drive out of range");

endmodule

bind turn_to_heading_controller_top tth_checker u_tth_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_drive (rsp_chan.drive)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn-to-heading controller testbench
// Drives heading samples through the valid/ready request channel, predicts
// drive, finished flag and average angle for every accepted transaction from
// a local model of the controller, and compares each returned result in
// order. Runs directed corner cases, a long output hold-off, and randomized
// approach-and-dwell heading sequences under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;

   localparam int AvgDivisor  = tth_pkg::AverageDivisorDefault;
   localparam int StallLimit  = 5000;
   localparam int HoldCycles  = 300;
   localparam int MaxReported = 10;

   // Indexes past the last register; writes to them must be ignored.
   localparam logic [tth_pkg::CsrIndexWidth-1:0] UNUSED_INDEX_LOW  = 3'd6;
   localparam logic [tth_pkg::CsrIndexWidth-1:0] UNUSED_INDEX_HIGH = 3'd7;

   typedef struct {
      logic signed [tth_pkg::DriveWidth-1:0] drive;
      logic                                  finished;
      logic [tth_pkg::HeadingWidth-1:0]      average_angle;
   } turn_result_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              csr_wr_en;
   logic [tth_pkg::CsrIndexWidth-1:0] csr_index;
   logic [tth_pkg::CsrDataWidth-1:0]  csr_wdata;

   tth_req_if req_if ();
   tth_rsp_if rsp_if ();

   turn_to_heading_controller_top #(
      .AVERAGE_DIVISOR(AvgDivisor)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Model copy of the registers and the running average, at reset values.
   logic signed [tth_pkg::AngleWidth-1:0] cfg_target_angle = '0;
   logic                                  cfg_azimuth_mode = 1'b0;
   logic [tth_pkg::SpeedWidth-1:0]        cfg_base_speed   = '0;
   logic [tth_pkg::GainWidth-1:0]         cfg_adjust_gain  = '0;
   logic [tth_pkg::TolWidth-1:0]          cfg_actual_tol   = '0;
   logic [tth_pkg::TolWidth-1:0]          cfg_average_tol  = '0;
   logic [tth_pkg::AvgWidth-1:0]          heading_average  = '0;

   turn_result_type pending_results[$];

   int req_idle_pct   = 0;
   int rsp_stall_pct  = 0;
   int hold_requests  = 0;
   int mismatch_count = 0;
   int items_offered  = 0;

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Setpoint after the azimuth wrap and half-degree nudge, plus direction.
   function automatic longint effective_setpoint(output bit clockwise);
      longint sp;
      sp = longint'(cfg_target_angle);
      if (cfg_azimuth_mode && sp < 0) sp += tth_pkg::Deg360;
      clockwise = sp < tth_pkg::Deg180;
      if (cfg_azimuth_mode) sp += clockwise ? tth_pkg::HalfDeg : -tth_pkg::HalfDeg;
      return sp;
   endfunction

   // Computes the result of one heading sample and advances the average.
   function automatic turn_result_type next_turn_result(
         input logic [tth_pkg::HeadingWidth-1:0] heading);
      longint          h, sp, tol, atol, err, mag, hc, drive, avg;
      bit              cw, fin;
      turn_result_type r;
      h    = longint'(heading);
      sp   = effective_setpoint(cw);
      tol  = longint'(cfg_actual_tol);
      atol = longint'(cfg_average_tol);

      // Magnitude uses the raw heading, even where clockwise mode folds it.
      err = (sp > h) ? sp - h : h - sp;
      mag = longint'(cfg_base_speed) + ((longint'(cfg_adjust_gain) * err) >> 16);
      if (mag > tth_pkg::DriveMax) mag = tth_pkg::DriveMax;

      if (cw) begin
         hc = (h > tth_pkg::Deg359) ? 0 : h;
         if (hc < sp - tol) drive = -mag;
         else if (hc > sp + tol) drive = mag;
         else drive = 0;
      end else begin
         hc = h;
         if (hc > sp + tol || hc < tth_pkg::Deg10) drive = mag;
         else if (hc < sp - tol) drive = -mag;
         else drive = 0;
      end

      avg = longint'(heading_average);
      avg = avg - avg / AvgDivisor + ((h << tth_pkg::FracBits) / AvgDivisor);
      heading_average = avg[tth_pkg::AvgWidth-1:0];
      avg = longint'(heading_average);

      fin = (avg - (atol << tth_pkg::FracBits)) < (hc << tth_pkg::FracBits)
         && (hc << tth_pkg::FracBits) < (avg + (atol << tth_pkg::FracBits))
         && (sp - tol) < hc
         && hc < (sp + tol);

      r.drive         = drive[tth_pkg::DriveWidth-1:0];
      r.finished      = fin;
      r.average_angle = heading_average[tth_pkg::AvgWidth-1 -: tth_pkg::HeadingWidth];
      return r;
   endfunction

   function automatic logic [tth_pkg::HeadingWidth-1:0] clamp_heading(input longint v);
      if (v < 0) return '0;
      if (v > 32767) return '1;
      return v[tth_pkg::HeadingWidth-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Offers one heading sample, with a random idle gap first, and records
   // the expected result once the transaction is accepted.
   task automatic offer_heading(input logic [tth_pkg::HeadingWidth-1:0] heading);
      if ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         do begin
            req_if.heading_change <= 15'($urandom_range(32767));
            @(posedge clock);
         end while ($urandom_range(99) < req_idle_pct);
      end
      req_if.valid          <= 1'b1;
      req_if.heading_change <= heading;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_results.push_back(next_turn_result(heading));
      items_offered++;
   endtask

   // Writes one register and mirrors the write in the model.
   task automatic write_register(input logic [tth_pkg::CsrIndexWidth-1:0] index,
                                 input logic [tth_pkg::CsrDataWidth-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         tth_pkg::REG_TARGET_ANGLE:      cfg_target_angle = data;
         tth_pkg::REG_AZIMUTH_MODE:      cfg_azimuth_mode = data[0];
         tth_pkg::REG_BASE_SPEED:        cfg_base_speed   = data[tth_pkg::SpeedWidth-1:0];
         tth_pkg::REG_ADJUST_GAIN:       cfg_adjust_gain  = data;
         tth_pkg::REG_ACTUAL_TOLERANCE:  cfg_actual_tol   = data[tth_pkg::TolWidth-1:0];
         tth_pkg::REG_AVERAGE_TOLERANCE: cfg_average_tol  = data[tth_pkg::TolWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [tth_pkg::CsrDataWidth-1:0] target, azimuth, base,
                             gain, tol, avg_tol);
      write_register(tth_pkg::REG_TARGET_ANGLE, target);
      write_register(tth_pkg::REG_AZIMUTH_MODE, azimuth);
      write_register(tth_pkg::REG_BASE_SPEED, base);
      write_register(tth_pkg::REG_ADJUST_GAIN, gain);
      write_register(tth_pkg::REG_ACTUAL_TOLERANCE, tol);
      write_register(tth_pkg::REG_AVERAGE_TOLERANCE, avg_tol);
   endtask

   // Stops offering and waits until every expected result has returned.
   task automatic drain_results;
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MaxReported) $display("MISMATCH: %s", msg);
   endtask

   // ------------------------------------------------------------------------
   // Result checker and receiver stalls
   // ------------------------------------------------------------------------
   initial begin : result_checker
      int              hold_left;
      int              hold_served;
      turn_result_type want;
      hold_left   = 0;
      hold_served = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               note_mismatch($sformatf("result with none expected: drive %0d finished %0d avg %0d",
                                       rsp_if.drive, rsp_if.finished, rsp_if.average_angle));
            end else begin
               want = pending_results.pop_front();
               if (rsp_if.drive !== want.drive)
                  note_mismatch($sformatf("drive expected %0d actual %0d",
                                          want.drive, rsp_if.drive));
               if (rsp_if.finished !== want.finished)
                  note_mismatch($sformatf("finished expected %0d actual %0d",
                                          want.finished, rsp_if.finished));
               if (rsp_if.average_angle !== want.average_angle)
                  note_mismatch($sformatf("average_angle expected %0d actual %0d",
                                          want.average_angle, rsp_if.average_angle));
            end
         end
         // A requested hold-off keeps ready low for a long stretch.
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: ends the run when no transaction moves for too long.
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < StallLimit) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Watchdog: no transaction for %0d cycles", StallLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // All registers at reset: setpoint zero, clockwise, empty bands.
   task automatic test_reset_defaults;
      offer_heading(15'd0);
      offer_heading(15'd32767);
      offer_heading(15'd16384);
   endtask

   // Clockwise turn to 90 degrees: band edges and the 359 degree fold.
   task automatic test_clockwise_bands;
      drain_results();
      set_config(16'd5760, 16'd0, 16'd1000, 16'd4096, 16'd64, 16'd8191);
      offer_heading(15'd0);
      offer_heading(15'd5695);
      offer_heading(15'd5696);
      offer_heading(15'd5824);
      offer_heading(15'd5825);
      offer_heading(15'd22977);
      offer_heading(15'd32767);
   endtask

   // Counter-clockwise turn to 270 degrees: forced positive drive below 10.
   task automatic test_counter_clockwise_bands;
      drain_results();
      set_config(16'd17280, 16'd0, 16'd1000, 16'd4096, 16'd64, 16'd8191);
      offer_heading(15'd0);
      offer_heading(15'd639);
      offer_heading(15'd640);
      offer_heading(15'd17215);
      offer_heading(15'd17345);
   endtask

   // Azimuth mode: negative wrap and the nudge on both sides of 180.
   task automatic test_azimuth_mode;
      drain_results();
      set_config(-16'sd5760, 16'd1, 16'd500, 16'd20000, 16'd32, 16'd4000);
      offer_heading(15'd17248);
      offer_heading(15'd0);
      drain_results();
      write_register(tth_pkg::REG_TARGET_ANGLE, -16'sd11520);
      offer_heading(15'd11488);
      drain_results();
      write_register(tth_pkg::REG_TARGET_ANGLE, 16'd11519);
      offer_heading(15'd11551);
      drain_results();
      write_register(tth_pkg::REG_TARGET_ANGLE, 16'h8000);
      offer_heading(15'd0);
   endtask

   // Zero bands give zero drive only on the setpoint; full gain saturates.
   task automatic test_zero_tolerance_and_saturation;
      drain_results();
      set_config(16'd5760, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      offer_heading(15'd5760);
      drain_results();
      set_config(16'd5760, 16'd0, 16'd32767, 16'd65535, 16'd0, 16'd0);
      offer_heading(15'd0);
   endtask

   // Upper bits beyond a register's width and unused indexes are ignored.
   task automatic test_register_masking;
      drain_results();
      set_config(16'd5760, 16'hFFFE, 16'hFFFF, 16'd100, 16'hFFFF, 16'hE000);
      write_register(UNUSED_INDEX_LOW, 16'hFFFF);
      write_register(UNUSED_INDEX_HIGH, 16'h1234);
      offer_heading(15'd23000);
   endtask

   // The receiver holds off while the sender keeps offering, so the block
   // fills and stalls its input.
   task automatic test_backpressure;
      drain_results();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      set_config(16'd5760, 16'd0, 16'd1000, 16'd4096, 16'd64, 16'd8191);
      hold_requests++;
      repeat (40) offer_heading(15'($urandom_range(32767)));
   endtask

   // Random register settings, weighted toward the extremes.
   task automatic randomize_config;
      logic [tth_pkg::CsrDataWidth-1:0] target, azimuth, base, gain, tol, avg_tol;
      case ($urandom_range(7))
         0:       target = 16'h8000;
         1:       target = -16'sd11520;
         2:       target = 16'd11519;
         3:       target = 16'd11520;
         4:       target = 16'd23039;
         5:       target = 16'h7FFF;
         default: target = 16'($urandom_range(65535));
      endcase
      azimuth = 16'($urandom_range(65535));
      case ($urandom_range(3))
         0:       base = 16'd0;
         1:       base = 16'hFFFF;
         default: base = 16'($urandom_range(4000))
                         | (16'($urandom_range(1)) << tth_pkg::SpeedWidth);
      endcase
      case ($urandom_range(3))
         0:       gain = 16'd0;
         1:       gain = 16'hFFFF;
         2:       gain = 16'($urandom_range(65535));
         default: gain = 16'($urandom_range(2000));
      endcase
      case ($urandom_range(4))
         0:       tol = 16'd0;
         1:       tol = 16'd5760;
         2:       tol = 16'h1FFF;
         default: tol = 16'($urandom_range(400))
                        | (16'($urandom_range(7)) << tth_pkg::TolWidth);
      endcase
      case ($urandom_range(4))
         0:       avg_tol = 16'd0;
         1:       avg_tol = 16'd5760;
         2:       avg_tol = 16'd8191;
         default: avg_tol = 16'($urandom_range(2000))
                            | (16'($urandom_range(7)) << tth_pkg::TolWidth);
      endcase
      set_config(target, azimuth, base, gain, tol, avg_tol);
   endtask

   // Heading closes in on the setpoint, then dwells inside the band so the
   // average settles and the finished flag can rise.
   task automatic run_approach_and_dwell;
      longint goal, h;
      int     spread, jitter;
      bit     cw;
      goal = longint'(clamp_heading(effective_setpoint(cw)));
      h    = longint'($urandom_range(32767));
      repeat ($urandom_range(2, 12)) begin
         jitter = int'($urandom_range(64)) - 32;
         h = h + (goal - h) / 2 + jitter;
         offer_heading(clamp_heading(h));
      end
      spread = (cfg_actual_tol > 512) ? 256 : int'(cfg_actual_tol) / 2;
      repeat ($urandom_range(6, 30)) begin
         jitter = int'($urandom_range(2 * spread)) - spread;
         offer_heading(clamp_heading(goal + jitter));
      end
   endtask

   task automatic test_random_phases;
      int idle_mix[4];
      int stall_mix[4];
      int start;
      idle_mix  = '{0, 63, 0, 38};
      stall_mix = '{0, 0, 63, 38};
      for (int phase = 0; phase < 4; phase++) begin
         req_idle_pct  = idle_mix[phase];
         rsp_stall_pct = stall_mix[phase];
         for (int block = 0; block < 5; block++) begin
            drain_results();
            randomize_config();
            start = items_offered;
            while (items_offered - start < 36) begin
               if ($urandom_range(9) < 8) begin
                  run_approach_and_dwell();
               end else begin
                  repeat ($urandom_range(1, 4)) offer_heading(15'($urandom_range(32767)));
               end
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_if.valid          = 1'b0;
      req_if.heading_change = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_clockwise_bands();
      test_counter_clockwise_bands();
      test_azimuth_mode();
      test_zero_tolerance_and_saturation();
      test_register_masking();
      test_backpressure();
      test_random_phases();

      drain_results();
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/tth_pkg.sv
rtl/tth_if.sv
rtl/tth_csr.sv
rtl/tth_core.sv
rtl/turn_to_heading_controller_top.sv
rtl/tth_checker.sv
test/testbench.sv
